### src/signed_int_to_decimal_ascii_defines.svh
// assertion macros for the converter rtl file
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef ASSERT_OFF
`define SITDA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SITDA_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SITDA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SITDA_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

### src/sitda_pkg.sv
`default_nettype none

package sitda_pkg;

	localparam int VALUE_BITS = 32;
	localparam int MAX_DIGITS = 10;

	// decimal digits of 2^(VALUE_BITS-1)
	localparam int BCD_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
	localparam int NCELLS     = (MAX_DIGITS > BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;
	localparam int CNT_W      = $clog2(NCELLS + 1);
	localparam int BIT_W      = $clog2(VALUE_BITS);

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic clr;
		logic dabble;
		logic move;
	} cell_ctl_t;

endpackage

`default_nettype wire

### src/sitda_digit_cell.sv
`default_nettype none

module sitda_digit_cell
	import sitda_pkg::*;
(
	input  wire logic       clk,
	input  wire cell_ctl_t  ctl,
	input  wire logic       bit_in,
	input  wire logic [3:0] digit_in,
	output logic            carry_out,
	output logic [3:0]      digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	// add-3 correction before the doubling shift
	assign adj       = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
	assign carry_out = adj[3];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			digit_q <= 4'd0;
		end else if (ctl.dabble) begin
			digit_q <= {adj[2:0], bit_in};
		end else if (ctl.move) begin
			digit_q <= digit_in;
		end
	end

endmodule

`default_nettype wire

### src/signed_int_to_decimal_ascii.sv
`default_nettype none

// Signed integer to decimal ASCII text. Each input beat carries a signed value and a
// digit count; the block answers with the text one character per output beat, tlast on
// the final one. Zero prints as a single '0'. A negative value gives '-' and then its
// magnitude, the most negative value included. A count of 1 to 10 prints exactly that
// many low-order digits (zero padded or truncated, the sign not counted); any other
// count prints the natural length. Method: the magnitude is shifted bit by bit through
// a row of ten BCD cells (double dabble), then the digits move up the row one per cycle
// (a digit load waits while the output register is still full) and are sent from the top
// cell. The next beat is taken once the last character has been loaded into the output
// register.
module signed_int_to_decimal_ascii
	import sitda_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // number [31:0], digit_count [35:32], zero fill
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // ascii_char [7:0]
	output logic             m_tlast
);

	`include "signed_int_to_decimal_ascii_defines.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]            state_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic                  sign_pend_q;
	logic                  fixed_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      rem_q;
	logic                  started_q;
	logic [BIT_W-1:0]      bit_q;
	logic                  m_tvalid_q;
	logic [7:0]            m_tdata_q;
	logic                  m_tlast_q;

	logic signed [31:0]    number;
	logic [3:0]            digit_count;
	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	logic                  is_zero;
	logic                  in_range;
	logic                  accept;
	logic                  out_free;
	logic                  skip;
	logic                  load_sign;
	logic                  do_skip;
	logic                  load_digit;
	logic [3:0]            top_digit;
	cell_ctl_t             ctl;

	logic [3:0] digits [NCELLS];
	logic       carry  [NCELLS];

	assign number      = s_tdata[31:0];
	assign digit_count = s_tdata[35:32];
	assign raw         = VALUE_BITS'(number);
	assign mag         = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
	assign is_zero     = (raw == '0);
	assign in_range    = digit_count inside {[1 : MAX_DIGITS]};

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign top_digit  = digits[NCELLS-1];
	assign out_free   = !m_tvalid_q || m_tready;
	assign skip       = fixed_q ? (rem_q > count_q) : (!started_q && (top_digit == 4'd0));
	assign load_sign  = (state_q == ST_EMIT) && sign_pend_q && out_free;
	assign do_skip    = (state_q == ST_EMIT) && !sign_pend_q && skip;
	assign load_digit = (state_q == ST_EMIT) && !sign_pend_q && !skip && out_free;

	always_comb begin
		ctl.clr    = accept;
		ctl.dabble = (state_q == ST_CONV);
		ctl.move   = do_skip || load_digit;
	end

	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		logic       bit_in;
		logic [3:0] digit_in;

		if (i == 0) begin : g_first
			assign bit_in   = mag_q[VALUE_BITS-1];
			assign digit_in = 4'd0;
		end else begin : g_next
			assign bit_in   = carry[i-1];
			assign digit_in = digits[i-1];
		end

		sitda_digit_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.bit_in    (bit_in),
			.digit_in  (digit_in),
			.carry_out (carry[i]),
			.digit     (digits[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sign_pend_q <= 1'b0;
			started_q   <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q     <= ST_CONV;
						sign_pend_q <= raw[VALUE_BITS-1];
						started_q   <= 1'b0;
					end
				end
				ST_CONV: begin
					if (bit_q == '0) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_sign) begin
						sign_pend_q <= 1'b0;
					end
					if (load_digit) begin
						started_q <= 1'b1;
						if (rem_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (load_sign || load_digit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q   <= mag;
			bit_q   <= BIT_W'(VALUE_BITS - 1);
			// zero prints as one fixed digit
			fixed_q <= is_zero || in_range;
			count_q <= is_zero ? CNT_W'(1) : CNT_W'(digit_count);
		end else if (state_q == ST_CONV) begin
			mag_q <= mag_q << 1;
			bit_q <= bit_q - 1'b1;
			rem_q <= CNT_W'(NCELLS);
		end else if (do_skip || load_digit) begin
			rem_q <= rem_q - 1'b1;
		end

		if (load_sign) begin
			m_tdata_q <= CHAR_MINUS;
			m_tlast_q <= 1'b0;
		end else if (load_digit) begin
			m_tdata_q <= CHAR_ZERO + {4'd0, top_digit};
			m_tlast_q <= (rem_q == CNT_W'(1));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	`SITDA_NEVER(a_rem_live, clk, arst_n, (state_q == ST_EMIT) && (rem_q == '0),
		"digit row exhausted while emitting")
	`SITDA_ASSERT(a_bcd_digit, clk, arst_n, (state_q == ST_EMIT) |-> (top_digit <= 4'd9),
		"top cell holds a non-decimal digit")
	`SITDA_NEVER(a_no_lead_zero, clk, arst_n,
		load_digit && !fixed_q && !started_q && (top_digit == 4'd0),
		"leading zero emitted in natural length mode")
	`SITDA_ASSERT(a_last_done, clk, arst_n, (load_digit && (rem_q == CNT_W'(1))) |=>
		(state_q == ST_IDLE && m_tvalid && m_tlast), "last character did not close the number")

endmodule

`default_nettype wire

### test/testbench.sv
`default_nettype none

module testbench;
	import sitda_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [3:0]         digit_count;
		logic signed [31:0] number;
	} number_item_t;

	typedef struct packed {
		logic [7:0] ascii;
		logic       last;
	} char_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;  // number [31:0], digit_count [35:32], zero fill
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;       // ascii_char [7:0]
	logic        m_tlast;

	number_item_t pending_numbers[$];
	char_beat_t   expected_chars[$];
	int           mismatch_count = 0;

	number_item_t current_number;
	int           src_wait = 0;
	int           src_gap;
	bit           src_burst = 1'b0;
	int           sink_wait = 0;
	int           sink_gap;
	bit           sink_burst = 1'b0;

	signed_int_to_decimal_ascii DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// decimal text of one number, pushed as expected character beats
	function automatic void predict_text(input logic signed [31:0] value, input logic [3:0] width);
		logic [31:0] magnitude;
		logic [3:0]  digits [0:11];
		int          natural;
		int          shown;
		char_beat_t  beat;

		if (value == 0) begin
			beat.ascii = CHAR_ZERO;
			beat.last = 1'b1;
			expected_chars.push_back(beat);
			return;
		end
		// unsigned magnitude, so the most negative value comes out as 2^31
		magnitude = value[31] ? (~value + 32'd1) : value;
		if (value[31]) begin
			beat.ascii = CHAR_MINUS;
			beat.last = 1'b0;
			expected_chars.push_back(beat);
		end
		foreach (digits[i])
			digits[i] = 4'd0;
		natural = 0;
		while (magnitude != 0) begin
			digits[natural] = 4'(magnitude % 10);
			magnitude = magnitude / 10;
			natural++;
		end
		shown = (width >= 1 && width <= MAX_DIGITS) ? int'(width) : natural;
		for (int j = shown - 1; j >= 0; j--) begin
			beat.ascii = CHAR_ZERO + 8'(digits[j]);
			beat.last = (j == 0);
			expected_chars.push_back(beat);
		end
	endfunction

	task automatic queue_number(input logic signed [31:0] value, input logic [3:0] width);
		number_item_t item;
		item.number = value;
		item.digit_count = width;
		pending_numbers.push_back(item);
	endtask

	// source side: one number per beat, random gaps between beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			src_wait <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_text(current_number.number, current_number.digit_count);
				if ($urandom_range(0, 29) == 0)
					src_burst = ~src_burst;
				src_gap = src_burst ? 0 : $urandom_range(0, 6);
				if (src_gap == 0 && pending_numbers.size() > 0) begin
					current_number = pending_numbers.pop_front();
					s_tdata <= {4'b0000, current_number.digit_count, current_number.number};
				end else begin
					s_tvalid <= 1'b0;
					src_wait <= (src_gap > 0) ? src_gap - 1 : 0;
				end
			end else if (!s_tvalid) begin
				if (src_wait > 0) begin
					src_wait <= src_wait - 1;
				end else if (pending_numbers.size() > 0) begin
					current_number = pending_numbers.pop_front();
					s_tdata <= {4'b0000, current_number.digit_count, current_number.number};
					s_tvalid <= 1'b1;
				end
			end
		end
	end

	// sink side: check each character beat, then stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_wait <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected char %02h last %0b", m_tdata, m_tlast));
				end else begin
					if (m_tdata !== expected_chars[0].ascii)
						report_mismatch($sformatf("char got %02h want %02h",
							m_tdata, expected_chars[0].ascii));
					if (m_tlast !== expected_chars[0].last)
						report_mismatch($sformatf("last got %0b want %0b on char %02h",
							m_tlast, expected_chars[0].last, expected_chars[0].ascii));
					void'(expected_chars.pop_front());
				end
				if ($urandom_range(0, 29) == 0)
					sink_burst = ~sink_burst;
				sink_gap = sink_burst ? 0 : $urandom_range(0, 6);
				if (sink_gap > 0) begin
					m_tready <= 1'b0;
					sink_wait <= sink_gap;
				end
			end else if (!m_tready) begin
				if (sink_wait > 1) begin
					sink_wait <= sink_wait - 1;
				end else begin
					m_tready <= 1'b1;
					sink_wait <= 0;
				end
			end
		end
	end

	initial begin
		int          n;
		int          p;
		logic [3:0]  w;

		// extremes, zero with any count, padding, truncation, sign handling
		queue_number(0, 0);
		queue_number(0, 7);
		queue_number(0, 15);
		queue_number(1, 0);
		queue_number(-1, 0);
		queue_number(32'sh7fff_ffff, 0);
		queue_number(32'sh7fff_ffff, 10);
		queue_number(32'sh7fff_ffff, 3);
		queue_number(32'sh7fff_ffff, 1);
		queue_number(32'sh8000_0000, 0);
		queue_number(32'sh8000_0000, 10);
		queue_number(32'sh8000_0000, 4);
		queue_number(32'sh8000_0000, 11);
		queue_number(123, 10);
		queue_number(123, 15);
		queue_number(-45, 5);
		queue_number(-7, 1);
		queue_number(1000000000, 0);
		queue_number(-1000000000, 9);
		queue_number(9, 2);
		queue_number(10, 1);
		queue_number(99, 11);
		queue_number(-99, 12);

		for (int i = 0; i < 410; i++) begin
			case ($urandom_range(0, 5))
				0, 1: n = $urandom;
				2: n = $urandom_range(0, 999);
				3: begin
					p = 1;
					repeat ($urandom_range(0, 9))
						p = p * 10;
					n = p + $urandom_range(0, 2) - 1;
				end
				4: begin
					case ($urandom_range(0, 4))
						0: n = 0;
						1: n = 1;
						2: n = -1;
						3: n = 32'sh7fff_ffff;
						default: n = 32'sh8000_0000;
					endcase
				end
				default: n = $urandom_range(0, 99999);
			endcase
			if ($urandom_range(0, 1) && n > 0 && n < 32'sh7fff_ffff)
				n = -n;
			w = 4'($urandom_range(0, 15));
			queue_number(n, w);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_numbers.size() > 0 || s_tvalid)
			@(posedge clk);
		while (expected_chars.size() > 0)
			@(posedge clk);
		// room for stray characters after the last one
		repeat (60) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#6_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
+incdir+src
src/sitda_pkg.sv
src/sitda_digit_cell.sv
src/signed_int_to_decimal_ascii.sv
test/testbench.sv
